@@ src/fmbq_pkg.sv @@
// Package for the front/middle/back queue: item types, command codes and
// default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmbq_pkg;

    localparam int HALF_DEPTH_DEF = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [2:0] CMD_PUSH_FRONT  = 3'd0;
    localparam logic [2:0] CMD_PUSH_MIDDLE = 3'd1;
    localparam logic [2:0] CMD_PUSH_BACK   = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT   = 3'd3;
    localparam logic [2:0] CMD_POP_MIDDLE  = 3'd4;
    localparam logic [2:0] CMD_POP_BACK    = 3'd5;

    localparam logic [31:0] POP_NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]          cmd;
        logic signed [31:0]  push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]  pop_value;
        logic                was_empty;
        logic                was_full;
        logic [11:0]         item_count;
    } t_out_item;

    typedef struct packed {
        logic re;
        logic we;
    } t_ram_ctl;

endpackage

`default_nettype wire

@@ src/fmbq_ram.sv @@
// Synchronous memory for one deque: one write and one read port, registered read.
// Depends on fmbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmbq_ram #(
    parameter int DEPTH = fmbq_pkg::HALF_DEPTH_DEF,
    parameter int WIDTH = fmbq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire fmbq_pkg::t_ram_ctl       i_ctl,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    import fmbq_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/fmbq_ctrl.sv @@
// Queue control: deque pointers and counts, command decode, read-modify-write
// sequencing of both deque memories and the output register. Depends on fmbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmbq_ctrl #(
    parameter int HALF_DEPTH = fmbq_pkg::HALF_DEPTH_DEF,
    parameter int DATA_WIDTH = fmbq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire fmbq_pkg::t_in_item            i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output fmbq_pkg::t_out_item                o_out_item,
    output fmbq_pkg::t_ram_ctl                 o_l_ctl,
    output logic [$clog2(HALF_DEPTH)-1:0]      o_l_waddr,
    output logic [DATA_WIDTH-1:0]              o_l_wdata,
    output logic [$clog2(HALF_DEPTH)-1:0]      o_l_raddr,
    input  wire logic [DATA_WIDTH-1:0]         i_l_rdata,
    output fmbq_pkg::t_ram_ctl                 o_r_ctl,
    output logic [$clog2(HALF_DEPTH)-1:0]      o_r_waddr,
    output logic [DATA_WIDTH-1:0]              o_r_wdata,
    output logic [$clog2(HALF_DEPTH)-1:0]      o_r_raddr,
    input  wire logic [DATA_WIDTH-1:0]         i_r_rdata
);
    import fmbq_pkg::*;

    localparam int AW = $clog2(HALF_DEPTH);
    localparam int CW = $clog2(HALF_DEPTH + 1);
    localparam int TW = $clog2(2 * HALF_DEPTH + 1);
    localparam logic [AW:0]   HD_EXT = (AW + 1)'(HALF_DEPTH);
    localparam logic [AW-1:0] LAST   = AW'(HALF_DEPTH - 1);
    localparam logic [TW-1:0] FULL   = TW'(2 * HALF_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] a, input logic [CW-1:0] c);
        logic [AW:0] s;
        s = (AW + 1)'(a) + (AW + 1)'(c);
        if (s >= HD_EXT) begin
            s = s - HD_EXT;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST : a - 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        return (a == LAST) ? '0 : a + 1'b1;
    endfunction

    logic                  r_state;
    logic                  n_state;
    logic [AW-1:0]         r_lh;
    logic [AW-1:0]         n_lh;
    logic [AW-1:0]         r_rh;
    logic [AW-1:0]         n_rh;
    logic [CW-1:0]         r_lc;
    logic [CW-1:0]         n_lc;
    logic [CW-1:0]         r_rc;
    logic [CW-1:0]         n_rc;
    logic [2:0]            r_cmd;
    logic [DATA_WIDTH-1:0] r_val;
    logic                  r_out_valid;
    t_out_item             r_out;
    t_out_item             n_out;

    logic                  accept;
    logic                  done;
    logic [TW-1:0]         total;
    logic                  is_full;
    logic                  is_empty;
    logic                  l_gt;
    logic                  l_eq;
    logic                  r_nz;
    logic [AW-1:0]         lb1;
    logic [AW-1:0]         lb;
    logic [AW-1:0]         rb1;
    logic [AW-1:0]         rb;
    logic [AW-1:0]         lfm;
    logic [AW-1:0]         rfm;
    logic                  l_we;
    logic                  r_we;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign done     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign total    = TW'(r_lc) + TW'(r_rc);
    assign is_full  = (total == FULL);
    assign is_empty = (total == '0);
    assign l_gt     = (r_lc > r_rc);
    assign l_eq     = (r_lc == r_rc);
    assign r_nz     = (r_rc != '0);
    assign lb1      = f_wrap(r_lh, r_lc);
    assign lb       = f_dec(lb1);
    assign rb1      = f_wrap(r_rh, r_rc);
    assign rb       = f_dec(rb1);
    assign lfm      = f_dec(r_lh);
    assign rfm      = f_dec(r_rh);

    // Read both deques at accept; pointers hold until the item completes.
    assign o_l_raddr = (i_in_item.cmd == CMD_POP_FRONT) ? r_lh : lb;
    assign o_r_raddr = (i_in_item.cmd == CMD_POP_BACK) ? rb : r_rh;

    always_comb begin
        n_lh      = r_lh;
        n_rh      = r_rh;
        n_lc      = r_lc;
        n_rc      = r_rc;
        l_we      = 1'b0;
        r_we      = 1'b0;
        o_l_waddr = lb1;
        o_l_wdata = r_val;
        o_r_waddr = rb1;
        o_r_wdata = r_val;
        n_out.pop_value = POP_NONE;
        n_out.was_empty = 1'b0;
        n_out.was_full  = 1'b0;
        unique case (r_cmd)
            CMD_PUSH_FRONT: begin
                if (is_full) begin
                    n_out.was_full = 1'b1;
                end else begin
                    if (l_gt) begin
                        r_we      = 1'b1;
                        o_r_waddr = rfm;
                        o_r_wdata = i_l_rdata;
                        n_rh      = rfm;
                        n_rc      = r_rc + 1'b1;
                    end else begin
                        n_lc = r_lc + 1'b1;
                    end
                    l_we      = 1'b1;
                    o_l_waddr = lfm;
                    n_lh      = lfm;
                end
            end
            CMD_PUSH_MIDDLE: begin
                if (is_full) begin
                    n_out.was_full = 1'b1;
                end else if (l_gt) begin
                    r_we      = 1'b1;
                    o_r_waddr = rfm;
                    o_r_wdata = i_l_rdata;
                    n_rh      = rfm;
                    n_rc      = r_rc + 1'b1;
                    l_we      = 1'b1;
                    o_l_waddr = lb;
                end else begin
                    l_we = 1'b1;
                    n_lc = r_lc + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (is_full) begin
                    n_out.was_full = 1'b1;
                end else if (l_eq) begin
                    l_we = 1'b1;
                    n_lc = r_lc + 1'b1;
                    if (r_nz) begin
                        o_l_wdata = i_r_rdata;
                        n_rh      = f_inc(r_rh);
                        r_we      = 1'b1;
                    end
                end else begin
                    r_we = 1'b1;
                    n_rc = r_rc + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (is_empty) begin
                    n_out.was_empty = 1'b1;
                end else begin
                    n_out.pop_value = 32'(i_l_rdata);
                    n_lh            = f_inc(r_lh);
                    if (l_eq) begin
                        l_we      = 1'b1;
                        o_l_wdata = i_r_rdata;
                        n_rh      = f_inc(r_rh);
                        n_rc      = r_rc - 1'b1;
                    end else begin
                        n_lc = r_lc - 1'b1;
                    end
                end
            end
            CMD_POP_MIDDLE: begin
                if (is_empty) begin
                    n_out.was_empty = 1'b1;
                end else begin
                    n_out.pop_value = 32'(i_l_rdata);
                    if (l_eq) begin
                        l_we      = 1'b1;
                        o_l_waddr = lb;
                        o_l_wdata = i_r_rdata;
                        n_rh      = f_inc(r_rh);
                        n_rc      = r_rc - 1'b1;
                    end else begin
                        n_lc = r_lc - 1'b1;
                    end
                end
            end
            CMD_POP_BACK: begin
                if (is_empty) begin
                    n_out.was_empty = 1'b1;
                end else if (r_nz) begin
                    n_out.pop_value = 32'(i_r_rdata);
                    if (l_gt) begin
                        r_we      = 1'b1;
                        o_r_waddr = rfm;
                        o_r_wdata = i_l_rdata;
                        n_rh      = rfm;
                        n_lc      = r_lc - 1'b1;
                    end else begin
                        n_rc = r_rc - 1'b1;
                    end
                end else begin
                    n_out.pop_value = 32'(i_l_rdata);
                    n_lc            = r_lc - 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_out.item_count = 12'(TW'(n_lc) + TW'(n_rc));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lh        <= '0;
            r_rh        <= '0;
            r_lc        <= '0;
            r_rc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done) begin
                r_lh        <= n_lh;
                r_rh        <= n_rh;
                r_lc        <= n_lc;
                r_rc        <= n_rc;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in_item.cmd;
            r_val <= DATA_WIDTH'($unsigned(i_in_item.push_value));
        end
        if (done) begin
            r_out <= n_out;
        end
    end

    assign o_l_ctl.re  = accept;
    assign o_l_ctl.we  = done && l_we;
    assign o_r_ctl.re  = accept;
    assign o_r_ctl.we  = done && r_we;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

@@ src/front_middle_back_queue_top.sv @@
// Top level of the front/middle/back queue: control plus the two deque memories.
// Depends on fmbq_pkg, fmbq_ctrl and fmbq_ram.
//
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_item) carries one command item:
//   push or pop at the front, the middle or the back, plus the push value.
//   Output channel (o_out_valid, i_out_stall, o_out_item) returns exactly one
//   result item per command: popped value (-1 for pushes, rejected or empty
//   cases), empty and full flags, and the item count after the command.
//   The queue lives in two deque memories of HALF_DEPTH entries each; the left
//   one holds the front half (the larger half when the count is odd).
//   The accept step reads both memories; the execute state then writes back
//   the pushed or moved entry and registers the result once the output
//   register is free. A new item is taken only after this single
//   read-then-write pass over the memory ports has completed.
//   A stalled result waits in the output register while the next item is
//   accepted and read; that item completes once the output register frees.
//   Reset (synchronous, active low) empties the queue at once; memory
//   contents are not cleared and are never used before being written.
`timescale 1ns / 1ps
`default_nettype none

module front_middle_back_queue_top #(
    parameter int HALF_DEPTH = fmbq_pkg::HALF_DEPTH_DEF,
    parameter int DATA_WIDTH = fmbq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire fmbq_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output fmbq_pkg::t_out_item      o_out_item
);
    import fmbq_pkg::*;

    localparam int AW = $clog2(HALF_DEPTH);

    t_ram_ctl              l_ctl;
    t_ram_ctl              r_ctl;
    logic [AW-1:0]         l_waddr;
    logic [AW-1:0]         l_raddr;
    logic [AW-1:0]         r_waddr;
    logic [AW-1:0]         r_raddr;
    logic [DATA_WIDTH-1:0] l_wdata;
    logic [DATA_WIDTH-1:0] l_rdata;
    logic [DATA_WIDTH-1:0] r_wdata;
    logic [DATA_WIDTH-1:0] r_rdata;

    fmbq_ctrl #(
        .HALF_DEPTH (HALF_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_l_ctl     (l_ctl),
        .o_l_waddr   (l_waddr),
        .o_l_wdata   (l_wdata),
        .o_l_raddr   (l_raddr),
        .i_l_rdata   (l_rdata),
        .o_r_ctl     (r_ctl),
        .o_r_waddr   (r_waddr),
        .o_r_wdata   (r_wdata),
        .o_r_raddr   (r_raddr),
        .i_r_rdata   (r_rdata)
    );

    fmbq_ram #(
        .DEPTH (HALF_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_left_ram (
        .i_clk   (i_clk),
        .i_ctl   (l_ctl),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    fmbq_ram #(
        .DEPTH (HALF_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_right_ram (
        .i_clk   (i_clk),
        .i_ctl   (r_ctl),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_raddr (r_raddr),
        .o_rdata (r_rdata)
    );

endmodule

`default_nettype wire

@@ src/fmbq_chk.sv @@
// Port-level checker for the front/middle/back queue, bound to the top level.
// Depends on fmbq_pkg and front_middle_back_queue_top.
`timescale 1ns / 1ps
`default_nettype none

module fmbq_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire fmbq_pkg::t_in_item  i_in_item,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire fmbq_pkg::t_out_item o_out_item
);
    import fmbq_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled while item in progress");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.was_empty |->
            (o_out_item.pop_value == -32'sd1) && (o_out_item.item_count == '0)
            && !o_out_item.was_full)
        else $error("empty pop result inconsistent");

endmodule

bind front_middle_back_queue_top fmbq_chk u_fmbq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
